// ----- rtl/zlc_pkg.sv -----
// Shared types, widths and the zoom step table of the zoom level controller.
// Used by zlc_div, zlc_seq and zoom_level_controller_core.
`default_nettype none
package zlc_pkg;

    localparam int DIM_BITS     = 16;
    localparam int FRAC_BITS    = 16;
    localparam int IZ_BITS      = 8 + FRAC_BITS;
    localparam int SZ_BITS      = 16 + FRAC_BITS;
    localparam int LVL_BITS     = 5;
    localparam int LEVEL_COUNT  = 25;
    localparam int DEF_LVL      = 13;
    localparam int DIV_BITS     = IZ_BITS + DIM_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
    localparam int PROD_BITS    = SZ_BITS + DIM_BITS;

    localparam logic [IZ_BITS-1:0] ONE_Q = IZ_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        OP_ZOOM_IN  = 2'd0,
        OP_ZOOM_OUT = 2'd1,
        OP_SET_MODE = 2'd2,
        OP_COMPUTE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_FIT  = 2'd1,
        MODE_FULL = 2'd2,
        MODE_BAD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        POL_ANY     = 2'd0,
        POL_ENLARGE = 2'd1,
        POL_REDUCE  = 2'd2,
        POL_UNUSED  = 2'd3
    } policy_t;

    localparam logic [0:0] REG_FIT_POLICY = 1'b0;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIM_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] shown_h;
        logic [DIM_BITS-1:0] shown_w;
        logic [SZ_BITS-1:0]  surface_zoom;
        logic [IZ_BITS-1:0]  image_zoom;
        logic [LVL_BITS-1:0] level_now;
        logic [1:0]          mode_now;
        logic                bad_mode;
        logic                step_done;
    } result_t;

    function automatic logic [IZ_BITS-1:0] step_value(input logic [LVL_BITS-1:0] idx);
        logic [IZ_BITS-1:0] v;
        unique case (idx)
            5'd0:    v = IZ_BITS'(655);
            5'd1:    v = IZ_BITS'(1311);
            5'd2:    v = IZ_BITS'(1966);
            5'd3:    v = IZ_BITS'(3277);
            5'd4:    v = IZ_BITS'(4588);
            5'd5:    v = IZ_BITS'(6554);
            5'd6:    v = IZ_BITS'(8192);
            5'd7:    v = IZ_BITS'(9830);
            5'd8:    v = IZ_BITS'(13107);
            5'd9:    v = IZ_BITS'(16384);
            5'd10:   v = IZ_BITS'(19661);
            5'd11:   v = IZ_BITS'(32768);
            5'd12:   v = IZ_BITS'(45875);
            5'd13:   v = IZ_BITS'(65536);
            5'd14:   v = IZ_BITS'(98304);
            5'd15:   v = IZ_BITS'(131072);
            5'd16:   v = IZ_BITS'(196608);
            5'd17:   v = IZ_BITS'(327680);
            5'd18:   v = IZ_BITS'(458752);
            5'd19:   v = IZ_BITS'(655360);
            5'd20:   v = IZ_BITS'(1310720);
            5'd21:   v = IZ_BITS'(1966080);
            5'd22:   v = IZ_BITS'(3276800);
            5'd23:   v = IZ_BITS'(4587520);
            default: v = IZ_BITS'(6553600);
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/zoom_level_controller_core.sv -----
// Top level of the zoom level controller: stream ports, APB register, output beat register.
// Depends on zlc_pkg and zlc_seq (which holds zlc_div).
//
// One beat at a time. Zoom in/out from fit mode first scans the step table, one table step
// per cycle. In fit mode, compute runs the shared bit-serial divider for the two fit ratios,
// and in every mode for the surface zoom when surface_w is nonzero; the single 32x16
// multiplier is used three times in turn.
// A finished beat waits in the output register while the next beat is accepted.
`default_nettype none
module zoom_level_controller_core
    import zlc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode_value[1:0], view_w[17:2], view_h[33:18], surface_w[49:34],
    // surface_h[65:50], image_w[81:66], image_h[97:82], zero[103:98]
    input  wire logic [103:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // step_done[0], bad_mode[1], mode_now[3:2], level_now[8:4], image_zoom[32:9],
    // surface_zoom[64:33], shown_w[80:65], shown_h[96:81], zero[103:97]
    output logic [103:0]      m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic          policy_we;
    logic [1:0]    policy_reg, policy_next;
    logic          m_valid_reg, m_valid_next;
    logic [103:0]  m_data_reg, m_data_next;
    logic          seq_idle;
    logic          res_load;
    logic          out_free;
    result_t       res;

    assign pready    = 1'b1;
    assign policy_we = psel && penable && pwrite && (paddr[2] == REG_FIT_POLICY);
    assign prdata    = (paddr[2] == REG_FIT_POLICY) ? {30'b0, policy_reg} : 32'b0;

    always_comb
    begin
        policy_next = policy_reg;
        if (policy_we)
            policy_next = pwdata[1:0];
    end

    assign out_free = !m_valid_reg || m_tready;

    zlc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_tvalid && s_tready),
        .opcode     (s_tuser),
        .mode_value (s_tdata[1:0]),
        .view_w     (s_tdata[17:2]),
        .view_h     (s_tdata[33:18]),
        .surface_w  (s_tdata[49:34]),
        .surface_h  (s_tdata[65:50]),
        .image_w    (s_tdata[81:66]),
        .image_h    (s_tdata[97:82]),
        .fit_policy (policy_reg),
        .out_free   (out_free),
        .idle       (seq_idle),
        .res_load   (res_load),
        .res        (res)
    );

    assign s_tready = seq_idle;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (res_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {7'b0, res};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_ANY;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg  <= policy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/zlc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on zlc_pkg for widths and the request/response structs.
`default_nettype none
module zlc_div
    import zlc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_BITS-1:0]     q_reg, q_next;
    logic [DIM_BITS:0]       rem_reg, rem_next;
    logic [DIM_BITS-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIM_BITS+1:0]     rem_sh;

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        rem_sh   = {rem_reg, q_reg[DIV_BITS-1]};
        if (req.start)
        begin
            q_next   = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = DIV_CNT_BITS'(DIV_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (rem_sh >= {2'b00, dvs_reg})
            begin
                rem_next = (DIM_BITS+1)'(rem_sh - {2'b00, dvs_reg});
                q_next   = {q_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIM_BITS:0];
                q_next   = {q_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.quotient = q_reg;

endmodule
`default_nettype wire

// ----- rtl/zlc_seq.sv -----
// Sequencer and datapath: zoom state, table scan, fit scale, surface zoom, shown sizes.
// Depends on zlc_pkg and drives one zlc_div instance.
`default_nettype none
module zlc_seq
    import zlc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            opcode,
    input  wire logic [1:0]            mode_value,
    input  wire logic [DIM_BITS-1:0]   view_w,
    input  wire logic [DIM_BITS-1:0]   view_h,
    input  wire logic [DIM_BITS-1:0]   surface_w,
    input  wire logic [DIM_BITS-1:0]   surface_h,
    input  wire logic [DIM_BITS-1:0]   image_w,
    input  wire logic [DIM_BITS-1:0]   image_h,
    input  wire logic [1:0]            fit_policy,
    input  wire logic                  out_free,
    output logic                       idle,
    output logic                       res_load,
    output result_t                    res
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SCAN  = 11'b000_0000_0010,
        S_STEP  = 11'b000_0000_0100,
        S_DIVA  = 11'b000_0000_1000,
        S_DIVB  = 11'b000_0001_0000,
        S_FIT   = 11'b000_0010_0000,
        S_MULI  = 11'b000_0100_0000,
        S_DIVS  = 11'b000_1000_0000,
        S_MULW  = 11'b001_0000_0000,
        S_MULH  = 11'b010_0000_0000,
        S_SHOWH = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 out_pend_reg, out_pend_next;
    logic [1:0]           mode_reg, mode_next;
    logic [LVL_BITS-1:0]  level_reg, level_next;
    logic [IZ_BITS-1:0]   fit_reg, fit_next;
    logic [LVL_BITS-1:0]  idx_reg, idx_next;
    logic                 go_reg, go_next;

    logic [1:0]           op_reg, op_next;
    logic [DIM_BITS-1:0]  vw_reg, vw_next, vh_reg, vh_next;
    logic [DIM_BITS-1:0]  sw_reg, sw_next, sh_reg, sh_next;
    logic [DIM_BITS-1:0]  iw_reg, iw_next, ih_reg, ih_next;
    logic [SZ_BITS-1:0]   a_reg, a_next;
    logic [IZ_BITS-1:0]   iz_reg, iz_next;
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic [SZ_BITS-1:0]   sz_reg, sz_next;
    logic [DIM_BITS-1:0]  ow_reg, ow_next, oh_reg, oh_next;
    logic                 done_reg, done_next, bad_reg, bad_next;

    logic [SZ_BITS-1:0]   mul_a;
    logic [DIM_BITS-1:0]  mul_b;
    logic [PROD_BITS-1:0] mul_p;
    logic [SZ_BITS-1:0]   smin;
    logic [IZ_BITS-1:0]   ssat;
    logic [SZ_BITS:0]     rnd;
    logic [DIM_BITS-1:0]  view_sel;
    logic [DIM_BITS-1:0]  shown;
    div_req_t             dreq;
    div_rsp_t             drsp;

    zlc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            S_MULI:  mul_a = SZ_BITS'(iz_reg);
            default: mul_a = sz_reg;
        endcase
        unique case (state_reg)
            S_MULI:  mul_b = iw_reg;
            S_MULW:  mul_b = sw_reg;
            default: mul_b = sh_reg;
        endcase
    end

    always_comb
    begin
        dreq.start = go_reg;
        unique case (state_reg)
            S_DIVA:
            begin
                dreq.dividend = DIV_BITS'({vw_reg, {FRAC_BITS{1'b0}}});
                dreq.divisor  = iw_reg;
            end
            S_DIVB:
            begin
                dreq.dividend = DIV_BITS'({vh_reg, {FRAC_BITS{1'b0}}});
                dreq.divisor  = ih_reg;
            end
            default:
            begin
                dreq.dividend = DIV_BITS'(prod_reg) + DIV_BITS'(sw_reg >> 1);
                dreq.divisor  = sw_reg;
            end
        endcase
    end

    always_comb
    begin
        smin = (a_reg < drsp.quotient[SZ_BITS-1:0]) ? a_reg : drsp.quotient[SZ_BITS-1:0];
        if (smin > SZ_BITS'({IZ_BITS{1'b1}}))
            ssat = {IZ_BITS{1'b1}};
        else
            ssat = smin[IZ_BITS-1:0];
        if (fit_policy == POL_ENLARGE && ssat < ONE_Q)
            ssat = ONE_Q;
        if (fit_policy == POL_REDUCE && ssat > ONE_Q)
            ssat = ONE_Q;
        rnd      = (SZ_BITS+1)'((prod_reg + PROD_BITS'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        view_sel = (state_reg == S_MULH) ? vw_reg : vh_reg;
        shown    = (rnd < (SZ_BITS+1)'(view_sel)) ? rnd[DIM_BITS-1:0] : view_sel;
    end

    always_comb
    begin
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        mode_next     = mode_reg;
        level_next    = level_reg;
        fit_next      = fit_reg;
        idx_next      = idx_reg;
        go_next       = 1'b0;
        op_next       = op_reg;
        vw_next       = vw_reg;
        vh_next       = vh_reg;
        sw_next       = sw_reg;
        sh_next       = sh_reg;
        iw_next       = iw_reg;
        ih_next       = ih_reg;
        a_next        = a_reg;
        iz_next       = iz_reg;
        prod_next     = prod_reg;
        sz_next       = sz_reg;
        ow_next       = ow_reg;
        oh_next       = oh_reg;
        done_next     = done_reg;
        bad_next      = bad_reg;
        res_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (out_pend_reg && out_free)
                begin
                    res_load      = 1'b1;
                    out_pend_next = 1'b0;
                end
                else if (start)
                begin
                    op_next   = opcode;
                    vw_next   = view_w;
                    vh_next   = view_h;
                    sw_next   = surface_w;
                    sh_next   = surface_h;
                    iw_next   = image_w;
                    ih_next   = image_h;
                    done_next = 1'b0;
                    bad_next  = 1'b0;
                    iz_next   = '0;
                    sz_next   = '0;
                    ow_next   = '0;
                    oh_next   = '0;
                    unique case (opcode)
                        OP_ZOOM_IN, OP_ZOOM_OUT:
                        begin
                            mode_next  = MODE_FREE;
                            state_next = S_STEP;
                            if (mode_reg == MODE_FULL)
                                level_next = LVL_BITS'(DEF_LVL);
                            if (mode_reg == MODE_FIT)
                            begin
                                level_next = '0;
                                idx_next   = LVL_BITS'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_SET_MODE:
                        begin
                            if (mode_value == MODE_BAD)
                                bad_next = 1'b1;
                            else
                                mode_next = mode_value;
                            out_pend_next = 1'b1;
                        end
                        default:
                        begin
                            if (image_w == '0 || image_h == '0)
                                out_pend_next = 1'b1;
                            else if (mode_reg == MODE_FIT)
                            begin
                                go_next    = 1'b1;
                                state_next = S_DIVA;
                            end
                            else
                            begin
                                iz_next    = (mode_reg == MODE_FULL) ? ONE_Q
                                                                     : step_value(level_reg);
                                state_next = S_MULI;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LVL_BITS'(LEVEL_COUNT))
                    state_next = S_STEP;
                else if (fit_reg >= step_value(idx_reg))
                begin
                    level_next = idx_reg;
                    idx_next   = idx_reg + 1'b1;
                end
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (op_reg == OP_ZOOM_IN)
                begin
                    if (level_reg < LVL_BITS'(LEVEL_COUNT - 1))
                    begin
                        level_next = level_reg + 1'b1;
                        done_next  = 1'b1;
                    end
                end
                else if (level_reg != '0)
                begin
                    level_next = level_reg - 1'b1;
                    done_next  = 1'b1;
                end
                out_pend_next = 1'b1;
                state_next    = S_IDLE;
            end
            S_DIVA:
            begin
                if (!go_reg && !drsp.busy)
                begin
                    a_next     = drsp.quotient[SZ_BITS-1:0];
                    go_next    = 1'b1;
                    state_next = S_DIVB;
                end
            end
            S_DIVB:
            begin
                if (!go_reg && !drsp.busy)
                    state_next = S_FIT;
            end
            S_FIT:
            begin
                iz_next    = ssat;
                fit_next   = ssat;
                state_next = S_MULI;
            end
            S_MULI:
            begin
                prod_next = mul_p;
                if (sw_reg != '0)
                begin
                    go_next    = 1'b1;
                    state_next = S_DIVS;
                end
                else
                    state_next = S_MULW;
            end
            S_DIVS:
            begin
                if (!go_reg && !drsp.busy)
                begin
                    if (drsp.quotient > DIV_BITS'({SZ_BITS{1'b1}}))
                        sz_next = {SZ_BITS{1'b1}};
                    else
                        sz_next = drsp.quotient[SZ_BITS-1:0];
                    state_next = S_MULW;
                end
            end
            S_MULW:
            begin
                prod_next  = mul_p;
                state_next = S_MULH;
            end
            S_MULH:
            begin
                ow_next    = shown;
                prod_next  = mul_p;
                state_next = S_SHOWH;
            end
            S_SHOWH:
            begin
                oh_next       = shown;
                out_pend_next = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_pend_reg <= 1'b0;
            mode_reg     <= MODE_FREE;
            level_reg    <= LVL_BITS'(DEF_LVL);
            fit_reg      <= ONE_Q;
            go_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
            mode_reg     <= mode_next;
            level_reg    <= level_next;
            fit_reg      <= fit_next;
            go_reg       <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        vw_reg   <= vw_next;
        vh_reg   <= vh_next;
        sw_reg   <= sw_next;
        sh_reg   <= sh_next;
        iw_reg   <= iw_next;
        ih_reg   <= ih_next;
        a_reg    <= a_next;
        iz_reg   <= iz_next;
        prod_reg <= prod_next;
        sz_reg   <= sz_next;
        ow_reg   <= ow_next;
        oh_reg   <= oh_next;
        done_reg <= done_next;
        bad_reg  <= bad_next;
    end

    assign idle = (state_reg == S_IDLE) && !out_pend_reg;

    assign res.step_done    = done_reg;
    assign res.bad_mode     = bad_reg;
    assign res.mode_now     = mode_reg;
    assign res.level_now    = level_reg;
    assign res.image_zoom   = iz_reg;
    assign res.surface_zoom = sz_reg;
    assign res.shown_w      = ow_reg;
    assign res.shown_h      = oh_reg;

endmodule
`default_nettype wire
